// ===== design/dapc_pkg.sv =====
`timescale 1ns / 1ps

package dapc_pkg;

   localparam logic [3:0] PORT_RESET = 4'h6;
   localparam logic [3:0] PORT_READ  = 4'hA;
   localparam logic [3:0] PORT_WRITE = 4'hC;
   localparam logic [3:0] PORT_POLL  = 4'hE;

   localparam logic [7:0] RESET_REPLY    = 8'hAA;
   localparam logic [7:0] READY_BIT      = 8'h80;
   localparam logic [7:0] UNMAPPED_READ  = 8'hFF;
   localparam logic [7:0] STATUS_READ    = 8'h00;
   localparam logic [7:0] CMD_TIME_CONST = 8'h40;
   localparam logic [7:0] CMD_BLOCK_LEN  = 8'h48;
   localparam logic [7:0] CMD_AUTO_PLAY  = 8'h1C;
   localparam logic [7:0] CMD_PAUSE      = 8'hD0;
   localparam logic [7:0] CMD_SPK_ON     = 8'hD1;
   localparam logic [7:0] CMD_SPK_OFF    = 8'hD3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_TICK  = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      K_NOP,
      K_RESET_WR,
      K_CMD_WR,
      K_RD_DATA,
      K_RD_STATUS,
      K_RD_POLL,
      K_RD_UNMAPPED,
      K_TICK
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

// ===== design/dapc_if.sv =====
`timescale 1ns / 1ps

interface dapc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [3:0] port_offset;
   logic [7:0] write_data;

   modport source (output valid, output opcode, output port_offset, output write_data,
                   input ready);
   modport sink   (input valid, input opcode, input port_offset, input write_data,
                   output ready);
endinterface

interface dapc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       sample_request;
   logic       irq_line;
   logic       speaker_enabled;

   modport source (output valid, output read_data, output sample_request,
                   output irq_line, output speaker_enabled, input ready);
   modport sink   (input valid, input read_data, input sample_request,
                   input irq_line, input speaker_enabled, output ready);
endinterface

// ===== design/dsp_audio_playback_controller.sv =====
`timescale 1ns / 1ps
// An accepted item is written into the queue, then executed from its head into the output register.
// Throughput: one item per cycle while the queue is not full; the back end executes one queued item per cycle
// whenever its output register is empty or being taken.
// Reset: synchronous, active high; clears the queue, the output valid flag and all
// DSP state (no command pending, playback stopped, speaker off, IRQ low).
module dsp_audio_playback_controller (
   input  logic       clock,
   input  logic       reset,
   dapc_req_if.sink   req_if,
   dapc_rsp_if.source rsp_if
);

   logic                     push;
   logic                     pop;
   logic                     queue_full;
   dapc_pkg::item_type       push_item;
   dapc_pkg::queue_head_type head;

   dapc_front u_front (
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   dapc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .head      (head)
   );

   dapc_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

// ===== design/dapc_front.sv =====
`timescale 1ns / 1ps

module dapc_front (
   dapc_req_if.sink          req_if,
   input  logic              queue_full,
   output logic              push,
   output dapc_pkg::item_type push_item
);

   dapc_pkg::opcode_type op;

   assign op            = dapc_pkg::opcode_type'(req_if.opcode);
   assign req_if.ready  = !queue_full;
   assign push          = req_if.valid && !queue_full;
   assign push_item.data = req_if.write_data;

   // decode port and opcode into one action for the back end
   always_comb begin
      push_item.kind = dapc_pkg::K_NOP;
      unique case (op)
         dapc_pkg::OP_WRITE: begin
            priority if (req_if.port_offset == dapc_pkg::PORT_RESET)
               push_item.kind = dapc_pkg::K_RESET_WR;
            else if (req_if.port_offset == dapc_pkg::PORT_WRITE)
               push_item.kind = dapc_pkg::K_CMD_WR;
            else
               push_item.kind = dapc_pkg::K_NOP;
         end
         dapc_pkg::OP_READ: begin
            priority if (req_if.port_offset == dapc_pkg::PORT_READ)
               push_item.kind = dapc_pkg::K_RD_DATA;
            else if (req_if.port_offset == dapc_pkg::PORT_WRITE)
               push_item.kind = dapc_pkg::K_RD_STATUS;
            else if (req_if.port_offset == dapc_pkg::PORT_POLL)
               push_item.kind = dapc_pkg::K_RD_POLL;
            else
               push_item.kind = dapc_pkg::K_RD_UNMAPPED;
         end
         dapc_pkg::OP_TICK: push_item.kind = dapc_pkg::K_TICK;
         dapc_pkg::OP_NOP:  push_item.kind = dapc_pkg::K_NOP;
      endcase
   end

endmodule

// ===== design/dapc_queue.sv =====
`timescale 1ns / 1ps

module dapc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  dapc_pkg::item_type       push_item,
   output logic                     full,
   input  logic                     pop,
   output dapc_pkg::queue_head_type head
);

   localparam logic [dapc_pkg::QUEUE_AW:0] DEPTH_CNT =
      (dapc_pkg::QUEUE_AW + 1)'(dapc_pkg::QUEUE_DEPTH);

   dapc_pkg::item_type mem [dapc_pkg::QUEUE_DEPTH];

   logic [dapc_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dapc_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dapc_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic                          do_pop;

   assign full       = (count_ff == DEPTH_CNT);
   assign head.valid = (count_ff != '0);
   assign head.item  = mem[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (!push && do_pop)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push)
         mem[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/dapc_back.sv =====
`timescale 1ns / 1ps

module dapc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  dapc_pkg::queue_head_type head,
   output logic                     pop,
   dapc_rsp_if.source               rsp_if
);

   typedef enum logic [1:0] {
      PEND_NONE,
      PEND_TC,
      PEND_LEN
   } pend_type;

   logic        reset_bit_ff, reset_bit_in;
   logic [7:0]  read_latch_ff, read_latch_in;
   logic        data_avail_ff, data_avail_in;
   pend_type    pend_ff, pend_in;
   logic        arg_idx_ff, arg_idx_in;
   logic [7:0]  time_const_ff, time_const_in;
   logic [15:0] block_len_ff, block_len_in;
   logic        speaker_ff, speaker_in;
   logic        playing_ff, playing_in;
   logic [7:0]  tick_cnt_ff, tick_cnt_in;
   logic [15:0] byte_cnt_ff, byte_cnt_in;
   logic        irq_ff, irq_in;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_data_ff, rsp_data_in;
   logic        rsp_req_ff, rsp_req_in;
   logic        rsp_irq_ff;
   logic        rsp_spk_ff;

   logic [7:0]  d;
   logic [7:0]  limit;

   assign pop   = head.valid && (!rsp_valid_ff || rsp_if.ready);
   assign d     = head.item.data;
   assign limit = 8'hFF - time_const_ff;

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.read_data       = rsp_data_ff;
   assign rsp_if.sample_request  = rsp_req_ff;
   assign rsp_if.irq_line        = rsp_irq_ff;
   assign rsp_if.speaker_enabled = rsp_spk_ff;

   always_comb begin
      reset_bit_in  = reset_bit_ff;
      read_latch_in = read_latch_ff;
      data_avail_in = data_avail_ff;
      pend_in       = pend_ff;
      arg_idx_in    = arg_idx_ff;
      time_const_in = time_const_ff;
      block_len_in  = block_len_ff;
      speaker_in    = speaker_ff;
      playing_in    = playing_ff;
      tick_cnt_in   = tick_cnt_ff;
      byte_cnt_in   = byte_cnt_ff;
      irq_in        = irq_ff;
      rsp_data_in   = '0;
      rsp_req_in    = 1'b0;

      unique case (head.item.kind)
         dapc_pkg::K_NOP: ;
         dapc_pkg::K_RESET_WR: begin
            reset_bit_in = d[0];
            // soft reset acts on the falling edge of the reset bit
            if (reset_bit_ff && !d[0]) begin
               read_latch_in = dapc_pkg::RESET_REPLY;
               data_avail_in = 1'b1;
               pend_in       = PEND_NONE;
               arg_idx_in    = 1'b0;
               playing_in    = 1'b0;
               irq_in        = 1'b0;
               speaker_in    = 1'b0;
            end
         end
         dapc_pkg::K_CMD_WR: begin
            priority if (pend_ff == PEND_TC) begin
               time_const_in = d;
               pend_in       = PEND_NONE;
               arg_idx_in    = 1'b0;
            end else if (pend_ff == PEND_LEN) begin
               if (!arg_idx_ff) begin
                  block_len_in = {block_len_ff[15:8], d};
                  arg_idx_in   = 1'b1;
               end else begin
                  block_len_in = {d, block_len_ff[7:0]};
                  arg_idx_in   = 1'b0;
                  pend_in      = PEND_NONE;
               end
            end else begin
               pend_in    = PEND_NONE;
               arg_idx_in = 1'b0;
               unique case (d)
                  dapc_pkg::CMD_TIME_CONST: pend_in = PEND_TC;
                  dapc_pkg::CMD_BLOCK_LEN:  pend_in = PEND_LEN;
                  dapc_pkg::CMD_AUTO_PLAY: begin
                     playing_in  = 1'b1;
                     tick_cnt_in = '0;
                     byte_cnt_in = block_len_ff;
                  end
                  dapc_pkg::CMD_PAUSE:   playing_in = 1'b0;
                  dapc_pkg::CMD_SPK_ON:  speaker_in = 1'b1;
                  dapc_pkg::CMD_SPK_OFF: speaker_in = 1'b0;
                  default: ;
               endcase
            end
         end
         dapc_pkg::K_RD_DATA: begin
            rsp_data_in   = read_latch_ff;
            data_avail_in = 1'b0;
         end
         dapc_pkg::K_RD_STATUS: rsp_data_in = dapc_pkg::STATUS_READ;
         dapc_pkg::K_RD_POLL: begin
            rsp_data_in = data_avail_ff ? dapc_pkg::READY_BIT : 8'h00;
            irq_in      = 1'b0;
         end
         dapc_pkg::K_RD_UNMAPPED: rsp_data_in = dapc_pkg::UNMAPPED_READ;
         dapc_pkg::K_TICK: begin
            if (playing_ff) begin
               if (tick_cnt_ff >= limit) begin
                  tick_cnt_in = '0;
                  rsp_req_in  = 1'b1;
                  // auto-init: reload the count at block end
                  if (byte_cnt_ff == '0) begin
                     irq_in      = 1'b1;
                     byte_cnt_in = block_len_ff;
                  end else begin
                     byte_cnt_in = byte_cnt_ff - 16'd1;
                  end
               end else begin
                  tick_cnt_in = tick_cnt_ff + 8'd1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_bit_ff  <= 1'b0;
         read_latch_ff <= '0;
         data_avail_ff <= 1'b0;
         pend_ff       <= PEND_NONE;
         arg_idx_ff    <= 1'b0;
         time_const_ff <= '0;
         block_len_ff  <= '0;
         speaker_ff    <= 1'b0;
         playing_ff    <= 1'b0;
         tick_cnt_ff   <= '0;
         byte_cnt_ff   <= '0;
         irq_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            reset_bit_ff  <= reset_bit_in;
            read_latch_ff <= read_latch_in;
            data_avail_ff <= data_avail_in;
            pend_ff       <= pend_in;
            arg_idx_ff    <= arg_idx_in;
            time_const_ff <= time_const_in;
            block_len_ff  <= block_len_in;
            speaker_ff    <= speaker_in;
            playing_ff    <= playing_in;
            tick_cnt_ff   <= tick_cnt_in;
            byte_cnt_ff   <= byte_cnt_in;
            irq_ff        <= irq_in;
         end
         if (pop)
            rsp_valid_ff <= 1'b1;
         else if (rsp_if.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
         rsp_req_ff  <= rsp_req_in;
         rsp_irq_ff  <= irq_in;
         rsp_spk_ff  <= speaker_in;
      end
   end

endmodule
